>>> hdl/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

    // One input item: push a value or apply an operator.
    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
        logic        [4:0]  op_code;
    } in_t;

    // One result item: stack top, entry count and error code.
    typedef struct packed {
        logic signed [31:0] top_value;
        logic        [4:0]  depth;
        logic        [1:0]  error;
    } out_t;

    // Action codes.
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_APPLY = 1'b1;

    // Operator codes.
    localparam logic [4:0] OP_LNOT = 5'd0;
    localparam logic [4:0] OP_BNOT = 5'd1;
    localparam logic [4:0] OP_NEG  = 5'd2;
    localparam logic [4:0] OP_MUL  = 5'd3;
    localparam logic [4:0] OP_DIV  = 5'd4;
    localparam logic [4:0] OP_MOD  = 5'd5;
    localparam logic [4:0] OP_ADD  = 5'd6;
    localparam logic [4:0] OP_SUB  = 5'd7;
    localparam logic [4:0] OP_SHL  = 5'd8;
    localparam logic [4:0] OP_SHR  = 5'd9;
    localparam logic [4:0] OP_LT   = 5'd10;
    localparam logic [4:0] OP_GT   = 5'd11;
    localparam logic [4:0] OP_LE   = 5'd12;
    localparam logic [4:0] OP_GE   = 5'd13;
    localparam logic [4:0] OP_EQ   = 5'd14;
    localparam logic [4:0] OP_NE   = 5'd15;
    localparam logic [4:0] OP_AND  = 5'd16;
    localparam logic [4:0] OP_OR   = 5'd17;
    localparam logic [4:0] OP_XOR  = 5'd18;
    localparam logic [4:0] OP_LAND = 5'd19;
    localparam logic [4:0] OP_LXOR = 5'd20;
    localparam logic [4:0] OP_LOR  = 5'd21;
    localparam logic [4:0] OP_SEL  = 5'd22;

    // Error codes.
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_DIV_ZERO  = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_B,
        ST_READ_C,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // What the commit step does to the stack.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PUSH,
        KIND_UNARY,
        KIND_BINARY,
        KIND_SELECT
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       rd_third;
        logic       cap_b;
        logic       cap_c;
        logic       div_start;
        logic       commit;
        kind_t      kind;
        logic [1:0] err;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       action;
        logic [4:0] op_code;
        logic       sp_lt1;
        logic       sp_lt2;
        logic       sp_lt3;
        logic       sp_full;
        logic       top_zero;
        logic       div_done;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> hdl/rpn_div.sv
`timescale 1ns / 1ps

module rpn_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quotient,
    output logic signed [31:0] remainder
);
    import rpn_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // One restoring step per cycle on the magnitudes.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        shifted   = {rem_reg[31:0], quo_reg[31]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = 5'd0;
            rem_next  = 33'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dsr_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            qneg_next = dividend[31] ^ divisor[31];
            rneg_next = dividend[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state clears on reset; the data registers need not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    // Restore the signs: the quotient truncates, the remainder follows the dividend.
    assign done      = done_reg;
    assign quotient  = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = rneg_reg ? (32'd0 - rem_reg[31:0]) : rem_reg[31:0];

endmodule

>>> hdl/rpn_datapath.sv
`timescale 1ns / 1ps

module rpn_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::in_t      in_data,
    input  logic              out_stall,
    output logic              out_valid,
    output rpn_pkg::out_t     out_data,
    input  rpn_pkg::ctl_cmd_t cmd,
    output rpn_pkg::dp_stat_t stat
);
    import rpn_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SW = $clog2(STACK_DEPTH + 1);

    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic          action_reg;
    logic [31:0]   value_reg;
    logic [4:0]    op_reg;
    logic [31:0]   top_reg, top_next;
    logic [31:0]   b_reg;
    logic [31:0]   c_reg;
    logic [SW-1:0] sp_reg, sp_next;
    logic          out_valid_reg;
    out_t          out_reg;

    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [31:0] div_r;

    logic [31:0]   a_val;
    logic [31:0]   unary_res;
    logic [31:0]   binary_res;
    logic [31:0]   result;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign a_val = top_reg;

    // Divider for div and mod; the dividend arrives straight from the read port.
    rpn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rd_data_reg),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Operand read address: entry below the top, or the one below that.
    assign rd_addr = cmd.rd_third ? AW'(sp_reg - SW'(3)) : AW'(sp_reg - SW'(2));

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Unary operators on the top.
    always_comb
    begin
        case (op_reg)
            OP_LNOT: unary_res = (a_val == 32'd0) ? 32'd1 : 32'd0;
            OP_BNOT: unary_res = ~a_val;
            default: unary_res = 32'd0 - a_val;
        endcase
    end

    // Binary operators: left operand b, right operand a.
    always_comb
    begin
        case (op_reg)
            OP_MUL:  binary_res = b_reg * a_val;
            OP_DIV:  binary_res = div_q;
            OP_MOD:  binary_res = div_r;
            OP_ADD:  binary_res = b_reg + a_val;
            OP_SUB:  binary_res = b_reg - a_val;
            OP_SHL:  binary_res = b_reg << a_val[4:0];
            OP_SHR:  binary_res = $signed(b_reg) >>> a_val[4:0];
            OP_LT:   binary_res = {31'd0, $signed(b_reg) < $signed(a_val)};
            OP_GT:   binary_res = {31'd0, $signed(b_reg) > $signed(a_val)};
            OP_LE:   binary_res = {31'd0, $signed(b_reg) <= $signed(a_val)};
            OP_GE:   binary_res = {31'd0, $signed(b_reg) >= $signed(a_val)};
            OP_EQ:   binary_res = {31'd0, b_reg == a_val};
            OP_NE:   binary_res = {31'd0, b_reg != a_val};
            OP_AND:  binary_res = b_reg & a_val;
            OP_OR:   binary_res = b_reg | a_val;
            OP_XOR:  binary_res = b_reg ^ a_val;
            OP_LAND: binary_res = {31'd0, (b_reg != 32'd0) && (a_val != 32'd0)};
            OP_LXOR: binary_res = {31'd0, (b_reg == 32'd0) != (a_val == 32'd0)};
            default: binary_res = {31'd0, (b_reg != 32'd0) || (a_val != 32'd0)};
        endcase
    end

    // Commit: stack write, new pointer and new top.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = AW'(sp_reg);
        wr_data  = unary_res;
        sp_next  = sp_reg;
        top_next = top_reg;
        result   = unary_res;
        if (cmd.commit)
        begin
            case (cmd.kind)
                KIND_PUSH:
                begin
                    wr_en    = 1'b1;
                    wr_data  = value_reg;
                    sp_next  = sp_reg + SW'(1);
                    top_next = value_reg;
                end
                KIND_UNARY:
                begin
                    result   = unary_res;
                    wr_en    = 1'b1;
                    wr_addr  = AW'(sp_reg - SW'(1));
                    wr_data  = result;
                    top_next = result;
                end
                KIND_BINARY:
                begin
                    result   = binary_res;
                    wr_en    = 1'b1;
                    wr_addr  = AW'(sp_reg - SW'(2));
                    wr_data  = result;
                    sp_next  = sp_reg - SW'(1);
                    top_next = result;
                end
                KIND_SELECT:
                begin
                    result   = (c_reg != 32'd0) ? b_reg : a_val;
                    wr_en    = 1'b1;
                    wr_addr  = AW'(sp_reg - SW'(3));
                    wr_data  = result;
                    sp_next  = sp_reg - SW'(2);
                    top_next = result;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // Item, operand and top registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg <= in_data.action;
            value_reg  <= in_data.value;
            op_reg     <= in_data.op_code;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rd_data_reg;
        end
        if (cmd.cap_c)
        begin
            c_reg <= rd_data_reg;
        end
        top_reg <= top_next;
        if (cmd.commit)
        begin
            out_reg.top_value <= (sp_next != SW'(0)) ? top_next : 32'd0;
            out_reg.depth     <= 5'(sp_next);
            out_reg.error     <= cmd.err;
        end
    end

    // Stack pointer and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg <= sp_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Status for the controller.
    assign stat.action   = action_reg;
    assign stat.op_code  = op_reg;
    assign stat.sp_lt1   = (sp_reg < SW'(1));
    assign stat.sp_lt2   = (sp_reg < SW'(2));
    assign stat.sp_lt3   = (sp_reg < SW'(3));
    assign stat.sp_full  = (sp_reg >= SW'(STACK_DEPTH));
    assign stat.top_zero = (top_reg == 32'd0);
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || !out_stall;

endmodule

>>> hdl/rpn_ctrl.sv
`timescale 1ns / 1ps

module rpn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rpn_pkg::dp_stat_t stat,
    output rpn_pkg::ctl_cmd_t cmd
);
    import rpn_pkg::*;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic [1:0] err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_NONE;
            err_reg   <= ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        err_next      = err_reg;
        cmd           = '0;
        cmd.kind      = kind_reg;
        cmd.err       = err_reg;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                kind_next  = KIND_NONE;
                err_next   = ERR_OK;
                if (stat.action == ACT_PUSH)
                begin
                    if (stat.sp_full)
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        kind_next = KIND_PUSH;
                    end
                end
                else if (stat.op_code <= OP_NEG)
                begin
                    if (stat.sp_lt1)
                    begin
                        err_next = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        kind_next = KIND_UNARY;
                    end
                end
                else if (stat.op_code <= OP_LOR)
                begin
                    if (stat.sp_lt2)
                    begin
                        err_next = ERR_UNDERFLOW;
                    end
                    else if ((stat.op_code == OP_DIV || stat.op_code == OP_MOD)
                             && stat.top_zero)
                    begin
                        err_next = ERR_DIV_ZERO;
                    end
                    else
                    begin
                        kind_next  = KIND_BINARY;
                        state_next = ST_READ_B;
                    end
                end
                else if (stat.op_code == OP_SEL)
                begin
                    if (stat.sp_lt3)
                    begin
                        err_next = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        kind_next  = KIND_SELECT;
                        state_next = ST_READ_B;
                    end
                end
            end
            ST_READ_B:
            begin
                cmd.cap_b    = 1'b1;
                cmd.rd_third = 1'b1;
                if (kind_reg == KIND_SELECT)
                begin
                    state_next = ST_READ_C;
                end
                else if (stat.op_code == OP_DIV || stat.op_code == OP_MOD)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_C:
            begin
                cmd.cap_c  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/rpn_stack_expression_evaluator.sv
`timescale 1ns / 1ps
// A push, unary operator or error goes from decode straight to the commit of its result;
// a binary operator first reads its left operand, the ternary select reads two operands and div
// or mod also waits for the 32-step divider; a stalled result register holds the commit back.
// One item at a time: the next item is taken once the previous result is registered.
// Reset clears the stack pointer (empty stack) and all control; stack entries are not cleared.
module rpn_stack_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rpn_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output rpn_pkg::out_t out_data
);
    import rpn_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpn_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> hdl/rpn_checker.sv
`timescale 1ns / 1ps

module rpn_checker #(
    parameter int STACK_DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input rpn_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input rpn_pkg::out_t out_data
);
    import rpn_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // One item at a time: a transfer in closes the input for the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in progress");

    // An empty stack reports zero on top.
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.depth == 5'd0 && STACK_DEPTH < 32 |->
        out_data.top_value == 32'sd0)
        else $error("empty stack with nonzero top");

    // Reported depth never exceeds the stack size.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_data.depth) <= 32'(STACK_DEPTH))
        else $error("depth beyond stack size");

endmodule

bind rpn_stack_expression_evaluator rpn_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
